// ===== sv/pfsc_pkg.sv =====
// Package: request and result types, register indexes and status codes of the framer.
`default_nettype none
package pfsc_pkg;

  // Action codes of an input request
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDENT    = 3'd0;
  localparam logic [2:0] CFG_VERSION  = 3'd1;
  localparam logic [2:0] CFG_TYPE     = 3'd2;
  localparam logic [2:0] CFG_SEC_HDR  = 3'd3;
  localparam logic [2:0] CFG_MAX_PLEN = 3'd4;
  localparam logic [2:0] CFG_CAPACITY = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_BAD_SEG  = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  // Fixed frame overheads
  localparam logic [16:0] FRAME_OVERHEAD = 17'd12;
  localparam logic [15:0] DFIELD_EXTRA   = 16'd2;

  // Reset values of the limit registers
  localparam logic [15:0] MAX_PLEN_RST = 16'd1024;
  localparam logic [15:0] CAPACITY_RST = 16'hFFFF;

  typedef struct packed {
    logic        action;
    logic [6:0]  device_id;
    logic [3:0]  data_type;
    logic [7:0]  segment_flag;
    logic [13:0] sequence_count;
    logic [15:0] segment_number;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_frame;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/packet_framer_with_sum_checksum_top.sv =====
// Top level: byte-serial telemetry framer with a 16-bit inverted byte-sum checksum.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//  out     | from block| out_valid_o / out_stall_i| out_data_o (out_item_t)
//  cfg     | to block  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A request is held in one request register and turned into results one per
//  cycle by a step counter, while the output is not stalled; the output register
//  takes one result a cycle unless stalled. A payload byte gives one result (three
//  when it closes the frame with the checksum), a start ten results (twelve with an
//  empty payload, one on an error). A payload byte outside a frame is consumed and
//  gives no result. Reset clears all control state; out_stall_i holds the output
//  register and, through it, the step counter and the input.
`default_nettype none
module packet_framer_with_sum_checksum_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire pfsc_pkg::in_item_t in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      pfsc_pkg::out_item_t out_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  import pfsc_pkg::*;

  // Configuration registers
  logic [15:0] ident_q;
  logic [2:0]  version_q;
  logic        type_bit_q;
  logic        sec_hdr_q;
  logic [15:0] max_plen_q;
  logic [15:0] capacity_q;

  // Request register and step counter
  in_item_t    item_q;
  logic        item_valid_q, item_valid_d;
  logic [3:0]  step_q, step_d;

  // Frame state
  logic [15:0] sum_q, sum_d;
  logic [15:0] left_q, left_d;
  logic        active_q, active_d;
  logic [15:0] total_q, total_d;

  // Output register
  out_item_t   out_q;
  logic        out_valid_q, out_valid_d;

  // Step decode
  out_item_t   res;
  logic        has_out;
  logic        is_last;
  logic        adv;
  logic        out_free;
  logic        accept;
  logic [1:0]  status;
  logic [16:0] need;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] dlen;
  logic [15:0] csum;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q    <= '0;
      version_q  <= '0;
      type_bit_q <= 1'b0;
      sec_hdr_q  <= 1'b0;
      max_plen_q <= MAX_PLEN_RST;
      capacity_q <= CAPACITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IDENT:    ident_q    <= cfg_data_i;
        CFG_VERSION:  version_q  <= cfg_data_i[2:0];
        CFG_TYPE:     type_bit_q <= cfg_data_i[0];
        CFG_SEC_HDR:  sec_hdr_q  <= cfg_data_i[0];
        CFG_MAX_PLEN: max_plen_q <= cfg_data_i;
        CFG_CAPACITY: capacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Header fields and start checks, from the held request
  assign need   = {1'b0, item_q.payload_length} + FRAME_OVERHEAD;
  assign word_a = {version_q, type_bit_q, sec_hdr_q, item_q.device_id, item_q.data_type};
  assign word_b = {item_q.segment_flag[1:0], item_q.sequence_count};
  assign dlen   = item_q.payload_length + DFIELD_EXTRA;
  assign csum   = ~sum_q;

  always_comb begin
    if (item_q.payload_length > max_plen_q) begin
      status = ST_TOO_LONG;
    end else if (item_q.segment_flag[7:2] != '0) begin
      status = ST_BAD_SEG;
    end else if (need > {1'b0, capacity_q}) begin
      status = ST_CAPACITY;
    end else begin
      status = ST_OK;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Result of the current step and the frame state that follows it
  always_comb begin
    res      = '0;
    has_out  = 1'b1;
    is_last  = 1'b0;
    sum_d    = sum_q;
    left_d   = left_q;
    active_d = active_q;
    total_d  = total_q;
    if (item_q.action == ACT_START) begin
      if (step_q == 4'd0) begin
        sum_d    = '0;
        left_d   = '0;
        active_d = 1'b0;
        total_d  = (status == ST_OK) ? need[15:0] : '0;
      end
      if (status != ST_OK) begin
        // error result: one request, one result
        res.last_of_frame = 1'b1;
        res.status        = status;
        is_last           = 1'b1;
      end else begin
        case (step_q)
          4'd0:    res.out_byte = ident_q[15:8];
          4'd1:    res.out_byte = ident_q[7:0];
          4'd2:    res.out_byte = word_a[15:8];
          4'd3:    res.out_byte = word_a[7:0];
          4'd4:    res.out_byte = word_b[15:8];
          4'd5:    res.out_byte = word_b[7:0];
          4'd6:    res.out_byte = dlen[15:8];
          4'd7:    res.out_byte = dlen[7:0];
          4'd8:    res.out_byte = item_q.segment_number[15:8];
          4'd9:    res.out_byte = item_q.segment_number[7:0];
          4'd10:   res.out_byte = csum[15:8];
          default: res.out_byte = csum[7:0];
        endcase
        // header bytes after the identifier go into the sum
        if (step_q >= 4'd2 && step_q <= 4'd9) begin
          sum_d = sum_q + {8'd0, res.out_byte};
        end
        if (step_q == 4'd9) begin
          left_d   = item_q.payload_length;
          active_d = (item_q.payload_length != '0);
          is_last  = (item_q.payload_length != '0);
        end
        if (step_q == 4'd11) begin
          res.last_of_frame = 1'b1;
          res.frame_length  = total_q;
          is_last           = 1'b1;
        end
      end
    end else if (!active_q) begin
      // stray payload byte
      has_out = 1'b0;
      is_last = 1'b1;
    end else begin
      case (step_q)
        4'd0: begin
          res.out_byte = item_q.payload_byte;
          sum_d        = sum_q + {8'd0, item_q.payload_byte};
          left_d       = left_q - 16'd1;
          is_last      = (left_q != 16'd1);
        end
        4'd1: res.out_byte = csum[15:8];
        default: begin
          res.out_byte      = csum[7:0];
          res.last_of_frame = 1'b1;
          res.frame_length  = total_q;
          active_d          = 1'b0;
          left_d            = '0;
          is_last           = 1'b1;
        end
      endcase
    end
  end

  // A step advances when its result has room, or when it gives none
  assign adv        = item_valid_q && (!has_out || out_free);
  assign in_stall_o = item_valid_q && !(adv && is_last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    step_d       = step_q;
    if (adv) begin
      step_d = is_last ? 4'd0 : step_q + 4'd1;
      if (is_last) begin
        item_valid_d = 1'b0;
      end
    end
    if (accept) begin
      item_valid_d = 1'b1;
    end
  end

  assign out_valid_d = (adv && has_out) || (out_valid_q && out_stall_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      sum_q        <= '0;
      left_q       <= '0;
      active_q     <= 1'b0;
      total_q      <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
      if (adv) begin
        sum_q    <= sum_d;
        left_q   <= left_d;
        active_q <= active_d;
        total_q  <= total_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (adv && has_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_err_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.last_of_frame)
    else $error("error result without last_of_frame");

  a_len_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_frame |-> (out_data_o.frame_length == '0))
    else $error("frame_length set on a non-final byte");

  // only the checksum steps of the closing byte run with nothing left
  a_active_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && (step_q == '0) |-> (left_q != '0))
    else $error("frame open with no payload bytes left");

  a_step_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> item_valid_q)
    else $error("step counter running without a request");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the telemetry framer with 16-bit byte-sum checksum.
`timescale 1ns / 1ps
module tb_top;
  import pfsc_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 5000; // exceeds the long hold-off (LONG_HOLD)
  localparam int LONG_HOLD = 400;

  typedef enum {PH_SETUP, PH_DIRECTED, PH_PRESSURE, PH_RANDOM} phase_e;
  typedef enum {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_SPARSE} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  packet_framer_with_sum_checksum_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Framer register copies, as seen by the predictor
  logic [15:0] cfg_ident    = '0;
  logic [2:0]  cfg_version  = '0;
  logic        cfg_type     = 1'b0;
  logic        cfg_sec_hdr  = 1'b0;
  logic [15:0] cfg_max_plen = MAX_PLEN_RST;
  logic [15:0] cfg_capacity = CAPACITY_RST;

  // Framer state copies
  logic [15:0] byte_sum    = '0;
  logic [15:0] bytes_due   = '0;
  logic        in_frame    = 1'b0;
  logic [15:0] frame_total = '0;

  out_item_t   frame_bytes_due[$];   // expected results, oldest first
  in_item_t    pending_reqs[$];      // requests not yet offered
  int          queued_count = 0;
  int          accepted_count = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        req_taken = 1'b0;
  phase_e      phase = PH_SETUP;

  function void push_result(logic [7:0] b, logic last, logic [1:0] st, logic [15:0] flen);
    out_item_t res;
    res.out_byte      = b;
    res.last_of_frame = last;
    res.status        = st;
    res.frame_length  = flen;
    frame_bytes_due.push_back(res);
  endfunction

  function void push_summed(logic [7:0] b);
    byte_sum = byte_sum + 16'(b);
    push_result(b, 1'b0, ST_OK, 16'h0);
  endfunction

  // Inverted sum, high byte first; the low byte closes the frame
  function void close_frame();
    logic [15:0] csum;
    csum = ~byte_sum;
    push_result(csum[15:8], 1'b0, ST_OK, 16'h0);
    push_result(csum[7:0], 1'b1, ST_OK, frame_total);
    in_frame  = 1'b0;
    bytes_due = '0;
  endfunction

  // Works out the frame bytes that one accepted request produces
  function void frame_predict(in_item_t r);
    logic [16:0] need;
    logic [1:0]  st;
    logic [15:0] hdr_a, hdr_b, dlen;
    if (r.action == ACT_START) begin
      // a start always drops any frame in progress
      in_frame    = 1'b0;
      bytes_due   = '0;
      byte_sum    = '0;
      frame_total = '0;
      need = {1'b0, r.payload_length} + FRAME_OVERHEAD;
      st = ST_OK;
      if (r.payload_length > cfg_max_plen) st = ST_TOO_LONG;
      else if (r.segment_flag[7:2] != '0) st = ST_BAD_SEG;
      else if (need > {1'b0, cfg_capacity}) st = ST_CAPACITY;
      if (st != ST_OK) begin
        push_result(8'h00, 1'b1, st, 16'h0);
      end else begin
        hdr_a = {cfg_version, cfg_type, cfg_sec_hdr, r.device_id, r.data_type};
        hdr_b = {r.segment_flag[1:0], r.sequence_count};
        dlen  = r.payload_length + DFIELD_EXTRA;
        frame_total = need[15:0];
        // identifier is not covered by the sum
        push_result(cfg_ident[15:8], 1'b0, ST_OK, 16'h0);
        push_result(cfg_ident[7:0], 1'b0, ST_OK, 16'h0);
        push_summed(hdr_a[15:8]);
        push_summed(hdr_a[7:0]);
        push_summed(hdr_b[15:8]);
        push_summed(hdr_b[7:0]);
        push_summed(dlen[15:8]);
        push_summed(dlen[7:0]);
        push_summed(r.segment_number[15:8]);
        push_summed(r.segment_number[7:0]);
        in_frame  = 1'b1;
        bytes_due = r.payload_length;
        if (r.payload_length == '0) close_frame();
      end
    end else if (in_frame) begin
      push_summed(r.payload_byte);
      bytes_due = bytes_due - 16'd1;
      if (bytes_due == '0) close_frame();
    end
  endfunction

  function void check_field(string field, int got, int want);
    if (got != want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Monitor: checks results, predicts on accepted requests, guards against hangs
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want = frame_bytes_due.pop_front();
          check_field("out_byte", int'(out_data.out_byte), int'(want.out_byte));
          check_field("last_of_frame", int'(out_data.last_of_frame),
                      int'(want.last_of_frame));
          check_field("status", int'(out_data.status), int'(want.status));
          check_field("frame_length", int'(out_data.frame_length),
                      int'(want.frame_length));
        end
      end
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        accepted_count++;
        frame_predict(in_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Driver: offers queued requests in bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: one long hold-off in the pressure phase, otherwise shifting patterns
  int          hold_left = 0;
  logic        held_once = 1'b0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (phase == PH_PRESSURE && !held_once) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_COIN:    out_stall <= 1'($urandom_range(0, 1));
        STALL_PATTERN: out_stall <= (mode_left % 4 != 0);
        default:       out_stall <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Register write; valid is left high for a following write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IDENT:    cfg_ident = val;
      CFG_VERSION:  cfg_version = val[2:0];
      CFG_TYPE:     cfg_type = val[0];
      CFG_SEC_HDR:  cfg_sec_hdr = val[0];
      CFG_MAX_PLEN: cfg_max_plen = val;
      CFG_CAPACITY: cfg_capacity = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] ident, logic [2:0] ver, logic typ, logic sec,
                           logic [15:0] max_plen, logic [15:0] cap);
    write_reg(CFG_IDENT, ident);
    write_reg(CFG_VERSION, 16'(ver));
    write_reg(CFG_TYPE, 16'(typ));
    write_reg(CFG_SEC_HDR, 16'(sec));
    write_reg(CFG_MAX_PLEN, max_plen);
    write_reg(CFG_CAPACITY, cap);
    end_writes();
  endtask

  function automatic in_item_t random_item();
    logic [95:0] wide;
    logic [$bits(in_item_t)-1:0] raw;
    in_item_t r;
    wide = {$urandom, $urandom, $urandom};
    raw = wide[$bits(in_item_t)-1:0];
    r = raw;
    r.payload_length = 16'($urandom_range(0, 65523));
    return r;
  endfunction

  function void queue_req(in_item_t r);
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  function void queue_start(logic [6:0] dev, logic [3:0] typ, logic [7:0] seg,
                            logic [13:0] seq, logic [15:0] segno, logic [15:0] plen);
    in_item_t r;
    r = random_item();
    r.action         = ACT_START;
    r.device_id      = dev;
    r.data_type      = typ;
    r.segment_flag   = seg;
    r.sequence_count = seq;
    r.segment_number = segno;
    r.payload_length = plen;
    queue_req(r);
  endfunction

  function void queue_data(logic [7:0] b);
    in_item_t r;
    r = random_item();
    r.action       = ACT_DATA;
    r.payload_byte = b;
    queue_req(r);
  endfunction

  // Mostly complete frames with random content; some bad starts, cut frames, strays
  task automatic queue_random_traffic(int target);
    int done_reqs;
    int kind;
    int bound;
    int plen;
    int nbytes;
    in_item_t r;
    done_reqs = 0;
    bound = int'(cfg_max_plen);
    if (cfg_capacity < 16'd12) bound = -1;
    else if (int'(cfg_capacity) - 12 < bound) bound = int'(cfg_capacity) - 12;
    while (done_reqs < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 17 && kind != 14 && kind != 15) begin
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if (bound < 0) plen = 0;
        else if (plen > bound) plen = bound;
        nbytes = (kind == 16 && plen > 0) ? $urandom_range(0, plen - 1) : plen;
        r = random_item();
        queue_start(r.device_id, r.data_type, 8'($urandom_range(0, 3)), r.sequence_count,
                    r.segment_number, 16'(plen));
        repeat (nbytes) queue_data(8'($urandom));
        done_reqs += nbytes + 1;
      end else if (kind < 19) begin
        // fully random start, mostly failing one of the checks
        r = random_item();
        r.action = ACT_START;
        queue_req(r);
        done_reqs++;
      end else begin
        repeat ($urandom_range(1, 3)) queue_data(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || frame_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, check order, empty payload, abandon, strays
    phase = PH_DIRECTED;
    write_all(16'hA55A, 3'd7, 1'b1, 1'b1, 16'd1024, 16'hFFFF);
    queue_start(7'h7F, 4'hF, 8'd3, 14'h3FFF, 16'hFFFF, 16'd0);
    queue_start(7'h00, 4'h0, 8'd0, 14'h0000, 16'h0000, 16'd2);
    queue_data(8'hFF);
    queue_data(8'h00);
    queue_data(8'h5A);
    queue_start(7'd5, 4'd3, 8'd1, 14'd100, 16'd1234, 16'd1025);
    queue_start(7'd5, 4'd3, 8'hFF, 14'd100, 16'd1, 16'd2000);
    queue_start(7'd9, 4'd9, 8'd4, 14'd1, 16'd1, 16'd4);
    queue_start(7'd33, 4'd6, 8'd2, 14'd7, 16'h0102, 16'd3);
    queue_data(8'h11);
    queue_start(7'd34, 4'd7, 8'd1, 14'd8, 16'h0304, 16'd1);
    queue_data(8'h22);
    queue_start(7'd35, 4'd8, 8'd0, 14'd9, 16'h0506, 16'd3);
    queue_data(8'h33);
    queue_start(7'd36, 4'd9, 8'h80, 14'd10, 16'h0708, 16'd1);
    queue_data(8'h44);
    wait_drained();

    // Capacity boundary and the largest payload length
    write_all(16'h0000, 3'd0, 1'b0, 1'b0, 16'd65523, 16'd14);
    queue_start(7'd1, 4'd2, 8'd3, 14'd3, 16'hBEEF, 16'd2);
    queue_data(8'hA5);
    queue_data(8'h5A);
    queue_start(7'd1, 4'd2, 8'd0, 14'd4, 16'h0001, 16'd3);
    queue_start(7'd1, 4'd2, 8'd0, 14'd5, 16'h0001, 16'd65523);
    wait_drained();
    write_reg(CFG_CAPACITY, 16'hFFFF);
    end_writes();
    queue_start(7'd2, 4'd1, 8'd1, 14'd6, 16'h1234, 16'd65523);
    queue_data(8'h01);
    queue_data(8'h80);
    queue_data(8'hFE);
    queue_start(7'd2, 4'd1, 8'd2, 14'd7, 16'h4321, 16'd0);
    wait_drained();
    write_reg(CFG_MAX_PLEN, 16'd0);
    write_reg(CFG_CAPACITY, 16'd12);
    end_writes();
    queue_start(7'd3, 4'd4, 8'd3, 14'd8, 16'h0F0F, 16'd0);
    queue_start(7'd3, 4'd4, 8'd3, 14'd9, 16'h0F0F, 16'd1);
    wait_drained();
    write_reg(CFG_CAPACITY, 16'd0);
    end_writes();
    queue_start(7'd3, 4'd4, 8'd0, 14'd10, 16'h0F0F, 16'd0);
    wait_drained();

    // Random traffic under one long result hold-off
    phase = PH_PRESSURE;
    write_all(16'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
              16'($urandom_range(48, 65523)), 16'hFFFF);
    queue_random_traffic(75);
    wait_drained();

    // Tight limits, so that many starts fail
    phase = PH_RANDOM;
    write_all(16'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
              16'($urandom_range(4, 30)), 16'($urandom_range(12, 50)));
    queue_random_traffic(80);
    wait_drained();

    // Widest limits
    write_all(16'hFFFF, 3'd7, 1'($urandom), 1'($urandom), 16'd65523, 16'hFFFF);
    queue_random_traffic(80);
    wait_drained();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
